// File: rtl/core/binary_midpoint_local_threshold_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef BINARY_MIDPOINT_LOCAL_THRESHOLD_MACROS_SVH
`define BINARY_MIDPOINT_LOCAL_THRESHOLD_MACROS_SVH

`define BMLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define BMLT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define BMLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/bmlt_pkg.sv
package bmlt_pkg;

  localparam int PIX_W = 8;
  localparam int ROW_W = 13;
  localparam int OROW_W = 12;
  localparam int HGT_W = 13;
  localparam int CFG_WID_W = 11;
  localparam int CFG_KER_W = 3;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [HGT_W-1:0] HEIGHT_LIMIT = 13'd4096;
  localparam logic [CFG_WID_W-1:0] WIDTH_RST = 11'd640;
  localparam logic [HGT_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [CFG_KER_W-1:0] KERNEL_RST = 3'd3;

  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KERNEL = 2'd2;

  localparam logic [PIX_W-1:0] PIX_ON = 8'd255;
  localparam logic [PIX_W-1:0] PIX_OFF = 8'd0;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic vld;
    pix_t hi;
    pix_t lo;
    pix_t ctr;
  } col_sum_t;

endpackage

// File: rtl/core/bmlt_line_store.sv
module bmlt_line_store import bmlt_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int SLOTS = 8
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic                         rd_en,
  input  logic [$clog2(DEPTH)-1:0]     addr,
  input  logic [$clog2(SLOTS)-1:0]     slot,
  input  pix_t                         wr_data,
  output logic [PIX_W*SLOTS-1:0]       rd_data
);

  logic [PIX_W*SLOTS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr][{slot, 3'b000} +: PIX_W] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

// File: rtl/core/binary_midpoint_local_threshold.sv
// Midpoint local threshold of an 8-bit grayscale raster stream. Each output is 255 when the
// centre pixel exceeds floor((max+min)/2) over a square window of radius
// floor((kernel_size-1)/2), clipped to the image, else 0. Unless out_ready stalls it, the
// block takes one item per clock and gives one result per clock; a result passes stages 1
// to 3 and the output register after the item that completes its window. Each item reads
// one column of the line store (2*MAX_RADIUS+2 rows side by side in one word) and writes
// at most one pixel into it, so the single store port sets the rate. Registers are latched
// by the first pixel of a frame. After a frame the host sends radius*width+radius drain
// items; the final result carries last_of_frame. The store needs no clearing after reset.
module binary_midpoint_local_threshold import bmlt_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_RADIUS = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     in_pixel_value,
  input  logic                 in_drain,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     out_out_pixel,
  output logic                 out_last_of_frame,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_RADIUS + 1);
  localparam int DW = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int SLOTS = 2 * MAX_RADIUS + 2;
  localparam int SW = $clog2(SLOTS);
  localparam int LANES = 2 * MAX_RADIUS + 1;
  localparam int LW = $clog2(LANES);

  logic [CFG_WID_W-1:0] cfg_width_r;
  logic [HGT_W-1:0]     cfg_height_r;
  logic [CFG_KER_W-1:0] cfg_kernel_r;

  logic [WW-1:0]        fw_r;
  logic [HGT_W-1:0]     fh_r;
  logic [RW-1:0]        fr_r;
  logic                 busy_r;
  logic [DW-1:0]        dly_r;

  logic [CW-1:0]        in_col_r;
  logic [ROW_W-1:0]     in_row_r;
  logic [SW-1:0]        in_slot_r;
  logic [CW-1:0]        ocol_r;
  logic [OROW_W-1:0]    orow_r;

  logic [WW-1:0]        sat_w, cur_w;
  logic [HGT_W-1:0]     sat_h, cur_h;
  logic [RW-1:0]        sat_r, cur_r;
  logic [DW-1:0]        sat_dly, cur_dly;
  logic [CFG_KER_W-1:0] k_rad;

  logic                 acc, live, emit, last, wr_en, in_col_end, ocol_end;
  pix_t                 wr_data;

  logic                 s1_v_r, s1_emit_r, s1_last_r;
  logic [ROW_W-1:0]     s1_row_r;
  logic [SW-1:0]        s1_slot_r;
  pix_t                 s1_pix_r;
  logic [RW-1:0]        s1_r_r;
  logic [HGT_W-1:0]     s1_h_r;
  logic [CW-1:0]        s1_ocol_r;
  logic [WW-1:0]        s1_w_r;
  logic [PIX_W*SLOTS-1:0] rd_q;

  pix_t                 lane_val [LANES];
  logic                 lane_ok  [LANES];
  col_sum_t             col_nxt;

  col_sum_t             win_r [LANES];
  logic                 s2_v_r, s2_emit_r, s2_last_r;
  logic [RW-1:0]        s2_r_r;
  logic [CW-1:0]        s2_ocol_r;
  logic [WW-1:0]        s2_w_r;
  logic                 win_ok [LANES];
  pix_t                 w_hi, w_lo, w_ctr;

  logic                 s3_v_r, s3_last_r;
  pix_t                 s3_hi_r, s3_lo_r, s3_ctr_r;
  logic [PIX_W:0]       mid_sum;
  pix_t                 thr;

  logic                 out_v_r, out_last_r;
  pix_t                 out_pix_r;

  logic                 o_en, s3_en, s2_en, s1_en;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= WIDTH_RST;
      cfg_height_r <= HEIGHT_RST;
      cfg_kernel_r <= KERNEL_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_WIDTH:  cfg_width_r  <= pwdata[CFG_WID_W-1:0];
        REG_HEIGHT: cfg_height_r <= pwdata[HGT_W-1:0];
        REG_KERNEL: cfg_kernel_r <= pwdata[CFG_KER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = {{(DATA_W-CFG_WID_W){1'b0}}, cfg_width_r};
      REG_HEIGHT: prdata = {{(DATA_W-HGT_W){1'b0}}, cfg_height_r};
      REG_KERNEL: prdata = {{(DATA_W-CFG_KER_W){1'b0}}, cfg_kernel_r};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    if (cfg_width_r == '0) begin
      sat_w = WW'(1);
    end else if (32'(cfg_width_r) > 32'(MAX_WIDTH)) begin
      sat_w = WW'(MAX_WIDTH);
    end else begin
      sat_w = WW'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      sat_h = HGT_W'(1);
    end else if (cfg_height_r > HEIGHT_LIMIT) begin
      sat_h = HEIGHT_LIMIT;
    end else begin
      sat_h = cfg_height_r;
    end
    k_rad = (cfg_kernel_r == '0) ? '0 : ((cfg_kernel_r - 3'd1) >> 1);
    if (32'(k_rad) > 32'(MAX_RADIUS)) begin
      sat_r = RW'(MAX_RADIUS);
    end else begin
      sat_r = RW'(k_rad);
    end
    sat_dly = DW'(sat_r) * DW'(sat_w) + DW'(sat_r);
  end

  assign cur_w   = busy_r ? fw_r : sat_w;
  assign cur_h   = busy_r ? fh_r : sat_h;
  assign cur_r   = busy_r ? fr_r : sat_r;
  assign cur_dly = busy_r ? dly_r : sat_dly;

  // Stage enables.
  assign o_en  = !out_v_r || out_ready;
  assign s3_en = !s3_v_r || o_en;
  assign s2_en = !s2_v_r || s3_en;
  assign s1_en = !s1_v_r || s2_en;
  assign in_ready = s1_en;

  assign acc  = in_valid && in_ready;
  assign live = busy_r || !in_drain;
  assign emit = (cur_dly == '0);
  assign last = emit && (32'(orow_r) == 32'(cur_h) - 32'd1) &&
                (32'(ocol_r) == 32'(cur_w) - 32'd1);
  assign in_col_end = (32'(in_col_r) == 32'(cur_w) - 32'd1);
  assign ocol_end   = (32'(ocol_r) == 32'(cur_w) - 32'd1);
  assign wr_en   = acc && live && (in_row_r < cur_h);
  assign wr_data = in_drain ? PIX_OFF : in_pixel_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      fw_r      <= '0;
      fh_r      <= '0;
      fr_r      <= '0;
      dly_r     <= '0;
      in_col_r  <= '0;
      in_row_r  <= '0;
      in_slot_r <= '0;
      ocol_r    <= '0;
      orow_r    <= '0;
    end else if (acc && live) begin
      if (!busy_r) begin
        fw_r <= sat_w;
        fh_r <= sat_h;
        fr_r <= sat_r;
      end
      if (last) begin
        busy_r    <= 1'b0;
        dly_r     <= '0;
        in_col_r  <= '0;
        in_row_r  <= '0;
        in_slot_r <= '0;
        ocol_r    <= '0;
        orow_r    <= '0;
      end else begin
        busy_r <= 1'b1;
        dly_r  <= emit ? '0 : cur_dly - 1'b1;
        if (in_col_end) begin
          in_col_r  <= '0;
          in_row_r  <= in_row_r + 1'b1;
          in_slot_r <= (in_slot_r == SW'(SLOTS - 1)) ? '0 : in_slot_r + 1'b1;
        end else begin
          in_col_r <= in_col_r + 1'b1;
        end
        if (emit) begin
          if (ocol_end) begin
            ocol_r <= '0;
            orow_r <= orow_r + 1'b1;
          end else begin
            ocol_r <= ocol_r + 1'b1;
          end
        end
      end
    end
  end

  bmlt_line_store #(
    .DEPTH (MAX_WIDTH),
    .SLOTS (SLOTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .rd_en   (acc && live),
    .addr    (in_col_r),
    .slot    (in_slot_r),
    .wr_data (wr_data),
    .rd_data (rd_q)
  );

  // Stage 1: column summary over the rows of the window.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_en) begin
      s1_v_r <= acc && live;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_row_r  <= in_row_r;
      s1_slot_r <= in_slot_r;
      s1_pix_r  <= wr_data;
      s1_r_r    <= cur_r;
      s1_h_r    <= cur_h;
      s1_emit_r <= emit;
      s1_last_r <= last;
      s1_ocol_r <= ocol_r;
      s1_w_r    <= cur_w;
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    if (k == 0) begin : g_new
      assign lane_val[k] = s1_pix_r;
    end else begin : g_old
      logic [SW-1:0] ls;
      assign ls = (s1_slot_r >= SW'(k)) ? s1_slot_r - SW'(k) : s1_slot_r + SW'(SLOTS - k);
      assign lane_val[k] = rd_q[{ls, 3'b000} +: PIX_W];
    end
    assign lane_ok[k] = (k <= 2 * int'(s1_r_r)) && (int'(s1_row_r) >= k) &&
                        (int'(s1_row_r) - k < int'(s1_h_r));
  end

  always_comb begin
    col_nxt.vld = 1'b0;
    col_nxt.hi  = PIX_OFF;
    col_nxt.lo  = PIX_ON;
    col_nxt.ctr = lane_val[LW'(s1_r_r)];
    for (int k = 0; k < LANES; k++) begin
      if (lane_ok[k]) begin
        col_nxt.vld = 1'b1;
        if (lane_val[k] > col_nxt.hi) begin
          col_nxt.hi = lane_val[k];
        end
        if (lane_val[k] < col_nxt.lo) begin
          col_nxt.lo = lane_val[k];
        end
      end
    end
  end

  // Stage 2: window of column summaries.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      for (int j = 0; j < LANES; j++) begin
        win_r[j] <= '0;
      end
    end else if (s2_en) begin
      s2_v_r <= s1_v_r;
      if (s1_v_r) begin
        win_r[0] <= col_nxt;
        for (int j = 1; j < LANES; j++) begin
          win_r[j] <= win_r[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_emit_r <= s1_emit_r;
      s2_last_r <= s1_last_r;
      s2_r_r    <= s1_r_r;
      s2_ocol_r <= s1_ocol_r;
      s2_w_r    <= s1_w_r;
    end
  end

  for (genvar j = 0; j < LANES; j++) begin : g_win
    assign win_ok[j] = win_r[j].vld && (j <= 2 * int'(s2_r_r)) &&
                       (int'(s2_ocol_r) + int'(s2_r_r) - j >= 0) &&
                       (int'(s2_ocol_r) + int'(s2_r_r) - j < int'(s2_w_r));
  end

  always_comb begin
    w_ctr = win_r[LW'(s2_r_r)].ctr;
    w_hi  = w_ctr;
    w_lo  = w_ctr;
    for (int j = 0; j < LANES; j++) begin
      if (win_ok[j]) begin
        if (win_r[j].hi > w_hi) begin
          w_hi = win_r[j].hi;
        end
        if (win_r[j].lo < w_lo) begin
          w_lo = win_r[j].lo;
        end
      end
    end
  end

  // Stage 3: window extremes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_en) begin
      s3_v_r <= s2_v_r && s2_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_hi_r   <= w_hi;
      s3_lo_r   <= w_lo;
      s3_ctr_r  <= w_ctr;
      s3_last_r <= s2_last_r;
    end
  end

  assign mid_sum = {1'b0, s3_hi_r} + {1'b0, s3_lo_r};
  assign thr     = mid_sum[PIX_W:1];

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (o_en) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_en) begin
      out_pix_r  <= (s3_ctr_r > thr) ? PIX_ON : PIX_OFF;
      out_last_r <= s3_last_r;
    end
  end

  assign out_valid         = out_v_r;
  assign out_out_pixel     = out_pix_r;
  assign out_last_of_frame = out_last_r;

endmodule

// File: rtl/core/bmlt_checker.sv
`include "binary_midpoint_local_threshold_macros.svh"

module bmlt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_out_pixel,
  input logic       pready
);

  `BMLT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_out_pixel), "Stalled result changed before its transfer.")
  `BMLT_ASSERT_IMP(a_out_binary, out_valid, (out_out_pixel == 8'd0) || (out_out_pixel == 8'd255), "Result pixel is neither 0 nor 255.")
  `BMLT_ASSERT_IMP(a_in_open, !out_valid || out_ready, in_ready, "Input blocked while the output side can move.")
  `BMLT_ASSERT(a_pready, pready, "Configuration port not ready.")

endmodule

bind binary_midpoint_local_threshold bmlt_checker u_bmlt_checker (.*);

// File: verif/tb_top.sv
module tb_top;
  import bmlt_pkg::*;

  typedef struct {
    pix_t pixel;
    logic last;
  } thresh_result_t;

  localparam int STORE_ROWS = 8;
  localparam int LINE_LEN = 1024;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [PIX_W-1:0] in_pixel_value;
  logic in_drain;
  logic out_valid;
  logic out_ready;
  logic [PIX_W-1:0] out_out_pixel;
  logic out_last_of_frame;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  thresh_result_t expected_q[$];
  int err_cnt;
  bit gaps_on;
  int stall_left;
  int random_items;

  pix_t line_mem[0:STORE_ROWS*LINE_LEN-1];
  int col_in, row_in, col_out, row_out;
  int reg_w, reg_h, reg_k;
  int fw, fh, fr;
  bit in_frame;

  binary_midpoint_local_threshold u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pixel_value(in_pixel_value), .in_drain(in_drain),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_out_pixel(out_out_pixel), .out_last_of_frame(out_last_of_frame),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  function automatic int eff_width(int w);
    return (w == 0) ? 1 : (w > LINE_LEN) ? LINE_LEN : w;
  endfunction

  function automatic int eff_height(int h);
    return (h == 0) ? 1 : (h > 4096) ? 4096 : h;
  endfunction

  function automatic int eff_radius(int k);
    int r;
    r = (k >= 1) ? (k - 1) / 2 : 0;
    return (r > 3) ? 3 : r;
  endfunction

  function automatic pix_t stored_pix(int row, int col);
    return line_mem[(row % STORE_ROWS) * LINE_LEN + (col % LINE_LEN)];
  endfunction

  function automatic pix_t midpoint_pixel(int row, int col);
    int hi, lo, v, y, x;
    int ctr;
    ctr = stored_pix(row, col);
    hi = ctr;
    lo = ctr;
    for (int dy = -fr; dy <= fr; dy++) begin
      y = row + dy;
      if (y < 0 || y >= fh) continue;
      for (int dx = -fr; dx <= fr; dx++) begin
        x = col + dx;
        if (x < 0 || x >= fw) continue;
        v = stored_pix(y, x);
        if (v > hi) hi = v;
        if (v < lo) lo = v;
      end
    end
    return (ctr > ((hi + lo) >> 1)) ? PIX_ON : PIX_OFF;
  endfunction

  function automatic void predict_item(pix_t pix, logic drn);
    int pos, delay;
    thresh_result_t res;
    if (!in_frame) begin
      if (drn) return;
      fw = eff_width(reg_w);
      fh = eff_height(reg_h);
      fr = eff_radius(reg_k);
      in_frame = 1;
    end
    if (row_in < fh)
      line_mem[(row_in % STORE_ROWS) * LINE_LEN + col_in] = drn ? PIX_OFF : pix;
    pos = row_in * fw + col_in;
    delay = fr * fw + fr;
    col_in++;
    if (col_in >= fw) begin
      col_in = 0;
      row_in++;
    end
    if (pos < delay) return;
    res.pixel = midpoint_pixel(row_out, col_out);
    res.last = 1'b0;
    if (row_out == fh - 1 && col_out == fw - 1) begin
      res.last = 1'b1;
      col_in = 0;
      row_in = 0;
      col_out = 0;
      row_out = 0;
      in_frame = 0;
    end else begin
      col_out++;
      if (col_out >= fw) begin
        col_out = 0;
        row_out++;
      end
    end
    expected_q.push_back(res);
  endfunction

  always @(posedge clk) begin
    thresh_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected transfer, pixel %0d last %0b", $time, out_out_pixel,
                 out_last_of_frame);
        err_cnt++;
      end else begin
        exp_res = expected_q.pop_front();
        if (out_out_pixel !== exp_res.pixel) begin
          $display("%0t: out_pixel expected %0d actual %0d", $time, exp_res.pixel,
                   out_out_pixel);
          err_cnt++;
        end
        if (out_last_of_frame !== exp_res.last) begin
          $display("%0t: last_of_frame expected %0b actual %0b", $time, exp_res.last,
                   out_last_of_frame);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic reg_write(logic [1:0] idx, int value, int mask);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if ((prdata & mask) !== (value & mask)) begin
      $display("%0t: register %0d read expected %0d actual %0d", $time, idx, value & mask,
               prdata & mask);
      err_cnt++;
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic configure(int w, int h, int k);
    wait_drained();
    reg_write(REG_WIDTH, w, 'h7FF);
    reg_w = w & 'h7FF;
    reg_write(REG_HEIGHT, h, 'h1FFF);
    reg_h = h & 'h1FFF;
    reg_write(REG_KERNEL, k, 'h7);
    reg_k = k & 'h7;
  endtask

  task automatic send_item(pix_t pix, logic drn);
    in_valid <= 1'b1;
    in_pixel_value <= pix;
    in_drain <= drn;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predict_item(pix, drn);
    random_items++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  function automatic pix_t pick_pixel();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // A frame is its pixels followed by radius*width+radius flush items. Some pixels may be
  // replaced by drains and some flush items by pixels; both are legal.
  task automatic run_frame(int w, int h, int k, int noise_pct, bit stray, bit hold_mid);
    int n_pix, n_flush, ew, er;
    configure(w, h, k);
    ew = eff_width(w);
    er = eff_radius(k);
    n_pix = ew * eff_height(h);
    n_flush = er * ew + er;
    if (stray) send_item(pick_pixel(), 1'b1);
    for (int i = 0; i < n_pix; i++) begin
      if (hold_mid && i == n_pix / 2) begin
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
      end
      send_item(pick_pixel(), $urandom_range(0, 99) < noise_pct);
    end
    for (int i = 0; i < n_flush; i++)
      send_item(pick_pixel(), !($urandom_range(0, 99) < noise_pct));
    in_valid <= 1'b0;
  endtask

  task automatic test_directed_frame();
    configure(4, 3, 3);
    send_item(8'd77, 1'b1);
    send_item(8'd0, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd128, 1'b0);
    send_item(8'd127, 1'b1);
    send_item(8'd255, 1'b0);
    send_item(8'd0, 1'b0);
    send_item(8'd1, 1'b0);
    send_item(8'd254, 1'b0);
    send_item(8'd200, 1'b0);
    send_item(8'd0, 1'b0);
    send_item(8'd100, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd0, 1'b1);
    send_item(8'd0, 1'b1);
    send_item(8'd99, 1'b0);
    send_item(8'd0, 1'b1);
    send_item(8'd0, 1'b1);
    in_valid <= 1'b0;
  endtask

  task automatic test_kernel_sizes();
    for (int k = 0; k < 8; k++) run_frame(5, 4, k, 10, 1'b0, 1'b0);
  endtask

  task automatic test_register_extremes();
    run_frame(0, 0, 0, 5, 1'b1, 1'b0);
    run_frame(1, 1, 7, 5, 1'b0, 1'b0);
    run_frame(7, 1, 7, 5, 1'b0, 1'b0);
    run_frame(1, 5, 7, 5, 1'b0, 1'b0);
    run_frame(2, 3, 6, 5, 1'b0, 1'b0);
  endtask

  task automatic test_random_frames();
    bit held;
    held = 0;
    while (random_items < 450) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      run_frame($urandom_range(1, 12), $urandom_range(1, 6), $urandom_range(0, 7),
                $urandom_range(0, 15), $urandom_range(0, 4) == 0, !held);
      held = 1;
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_pixel_value <= '0;
    in_drain <= 1'b0;
    out_ready <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    err_cnt = 0;
    stall_left = 0;
    random_items = 0;
    gaps_on = 1;
    foreach (line_mem[i]) line_mem[i] = PIX_OFF;
    col_in = 0;
    row_in = 0;
    col_out = 0;
    row_out = 0;
    in_frame = 0;
    reg_w = WIDTH_RST;
    reg_h = HEIGHT_RST;
    reg_k = KERNEL_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frame();
    test_kernel_sizes();
    test_register_extremes();
    test_random_frames();
    wait_drained();
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/bmlt_pkg.sv
rtl/core/bmlt_line_store.sv
rtl/core/binary_midpoint_local_threshold.sv
rtl/core/bmlt_checker.sv
verif/tb_top.sv
